// File: sv/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg - shared types and constants for the PID motor drive core
// Holds the default widths, register reset values, register indexes and the
// command struct between the controller and the datapath.
// ----------------------------------------------------------------------------
package pmd_pkg;

    localparam int ACC_WIDTH_DEF      = 32;
    localparam int GAIN_FRAC_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 3'd4;

    localparam logic signed [15:0] TARGET_RATE_RST  = 16'sd300;
    localparam logic [15:0]        KP_GAIN_RST      = 16'd4096;
    localparam logic [15:0]        KI_GAIN_RST      = 16'd410;
    localparam logic [15:0]        KD_GAIN_RST      = 16'd205;
    localparam logic [15:0]        OUTPUT_SCALE_RST = 16'd557;

    localparam logic [1:0] DIR_STOP    = 2'b00;
    localparam logic [1:0] DIR_FORWARD = 2'b01;
    localparam logic [1:0] DIR_REVERSE = 2'b11;

    localparam logic [7:0] SPEED_MAX = 8'd255;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_SUM,
        S_MUL_H,
        S_MUL_L,
        S_FRAC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        A_KP,
        A_KI,
        A_KD,
        A_SCALE
    } t_a_sel;

    typedef enum logic [2:0] {
        B_ERR,
        B_INTEG,
        B_DIFF,
        B_HI,
        B_LO
    } t_b_sel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_LOAD,
        ACC_ADD_FRAC
    } t_acc_op;

    typedef struct packed {
        logic    load;
        t_a_sel  a_sel;
        t_b_sel  b_sel;
        t_acc_op acc_op;
        logic    out_load;
    } t_cmd;

endpackage

// File: sv/pmd_ctrl.sv
// ----------------------------------------------------------------------------
// pmd_ctrl - sequencer for one PID tick
// Steps the shared multiplier through the three gain products and the two
// halves of the output scaling, and owns the handshakes.
// ----------------------------------------------------------------------------
module pmd_ctrl import pmd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.a_sel  = A_KP;
        o_cmd.b_sel  = B_ERR;
        o_cmd.acc_op = ACC_HOLD;
        o_cmd.out_load = 1'b0;
        o_in_ready   = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_P;
                end
            end
            S_MUL_P: begin
                o_cmd.a_sel  = A_KP;
                o_cmd.b_sel  = B_ERR;
                o_cmd.acc_op = ACC_CLEAR;
                n_state      = S_MUL_I;
            end
            S_MUL_I: begin
                o_cmd.a_sel  = A_KI;
                o_cmd.b_sel  = B_INTEG;
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_MUL_D;
            end
            S_MUL_D: begin
                o_cmd.a_sel  = A_KD;
                o_cmd.b_sel  = B_DIFF;
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_MUL_H;
            end
            S_MUL_H: begin
                o_cmd.a_sel = A_SCALE;
                o_cmd.b_sel = B_HI;
                n_state     = S_MUL_L;
            end
            S_MUL_L: begin
                // low half reads the sum before it is replaced by the high product
                o_cmd.a_sel  = A_SCALE;
                o_cmd.b_sel  = B_LO;
                o_cmd.acc_op = ACC_LOAD;
                n_state      = S_FRAC;
            end
            S_FRAC: begin
                o_cmd.acc_op = ACC_ADD_FRAC;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sv/pmd_datapath.sv
// ----------------------------------------------------------------------------
// pmd_datapath - PID arithmetic with one shared multiplier
// Holds the configuration registers, the error state, the saturating
// integral, the product and sum registers and the output word register.
// ----------------------------------------------------------------------------
module pmd_datapath import pmd_pkg::*; #(
    parameter int ACC_WIDTH      = ACC_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic signed [15:0]     i_rate_sample,
    output logic signed [31:0]     o_scaled_drive,
    output logic [7:0]             o_motor_speed,
    output logic signed [1:0]      o_motor_direction,
    output logic [7:0]             o_pwm_a_duty,
    output logic [7:0]             o_pwm_b_duty
);

    localparam int SUM_W  = ACC_WIDTH + 18;
    localparam int PROD_W = ACC_WIDTH + 17;
    localparam int HI_W   = SUM_W - GAIN_FRAC_BITS - 16;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [15:0]          r_target;
    logic [15:0]                 r_kp, r_ki, r_kd, r_scale;
    logic signed [ACC_WIDTH-1:0] r_integ;
    logic signed [16:0]          r_last;
    logic signed [16:0]          r_err;
    logic signed [17:0]          r_diff;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SUM_W-1:0]     r_acc;
    logic signed [SUM_W-1:0]     n_acc;

    logic signed [31:0] r_scaled_drive;
    logic [7:0]         r_speed, r_pwm_a, r_pwm_b;
    logic [1:0]         r_dir;

    logic signed [16:0]          w_err;
    logic signed [17:0]          w_diff;
    logic signed [ACC_WIDTH:0]   w_isum;
    logic signed [ACC_WIDTH-1:0] w_integ;
    logic [15:0]                 w_a_raw;
    logic signed [16:0]          w_a;
    logic signed [ACC_WIDTH-1:0] w_b;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [SUM_W-1:0]     w_prod_ext;
    logic [HI_W-1:0]             w_hi;

    logic                    w_neg, w_zero, w_fits, w_big;
    logic [SUM_W-1:0]        w_mag;
    logic [7:0]              w_speed;
    logic signed [31:0]      w_sat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RATE_RST;
            r_kp     <= KP_GAIN_RST;
            r_ki     <= KI_GAIN_RST;
            r_kd     <= KD_GAIN_RST;
            r_scale  <= OUTPUT_SCALE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_TARGET_RATE:  r_target <= i_cfg_data;
                CFG_KP_GAIN:      r_kp     <= i_cfg_data;
                CFG_KI_GAIN:      r_ki     <= i_cfg_data;
                CFG_KD_GAIN:      r_kd     <= i_cfg_data;
                CFG_OUTPUT_SCALE: r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // error, integral and difference
    assign w_err  = {r_target[15], r_target} - {i_rate_sample[15], i_rate_sample};
    assign w_diff = {w_err[16], w_err} - {r_last[16], r_last};
    assign w_isum = {r_integ[ACC_WIDTH-1], r_integ}
                  + {{(ACC_WIDTH-16){w_err[16]}}, w_err};

    always_comb begin
        if (w_isum[ACC_WIDTH] != w_isum[ACC_WIDTH-1]) begin
            w_integ = w_isum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            w_integ = w_isum[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else if (i_cmd.load) begin
            r_integ <= w_integ;
            r_last  <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err  <= w_err;
            r_diff <= w_diff;
        end
    end

    // shared multiplier: unsigned 16-bit coefficient by a signed operand
    assign w_hi = r_acc[SUM_W-1:GAIN_FRAC_BITS+16];

    always_comb begin
        case (i_cmd.a_sel)
            A_KP:    w_a_raw = r_kp;
            A_KI:    w_a_raw = r_ki;
            A_KD:    w_a_raw = r_kd;
            A_SCALE: w_a_raw = r_scale;
            default: w_a_raw = '0;
        endcase
    end

    assign w_a = {1'b0, w_a_raw};

    always_comb begin
        case (i_cmd.b_sel)
            B_ERR:   w_b = {{(ACC_WIDTH-17){r_err[16]}}, r_err};
            B_INTEG: w_b = r_integ;
            B_DIFF:  w_b = {{(ACC_WIDTH-18){r_diff[17]}}, r_diff};
            B_HI:    w_b = {{(ACC_WIDTH-HI_W){w_hi[HI_W-1]}}, w_hi};
            B_LO:    w_b = {{(ACC_WIDTH-16){1'b0}},
                            r_acc[GAIN_FRAC_BITS+15:GAIN_FRAC_BITS]};
            default: w_b = '0;
        endcase
    end

    assign w_prod     = w_a * w_b;
    assign w_prod_ext = {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // accumulator
    always_comb begin
        case (i_cmd.acc_op)
            ACC_HOLD:     n_acc = r_acc;
            ACC_CLEAR:    n_acc = '0;
            ACC_ADD:      n_acc = r_acc + w_prod_ext;
            ACC_LOAD:     n_acc = w_prod_ext;
            ACC_ADD_FRAC: n_acc = r_acc + {{(SUM_W-16){1'b0}}, r_prod[31:16]};
            default:      n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // output word from the scaled value
    assign w_neg   = r_acc[SUM_W-1];
    assign w_zero  = ~|r_acc;
    assign w_fits  = (&r_acc[SUM_W-1:31]) | ~(|r_acc[SUM_W-1:31]);
    assign w_mag   = w_neg ? -r_acc : r_acc;
    assign w_big   = |w_mag[SUM_W-1:8];
    assign w_speed = w_big ? SPEED_MAX : w_mag[7:0];
    assign w_sat   = w_fits ? r_acc[31:0]
                   : (w_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_scaled_drive <= w_sat;
            if (w_zero) begin
                r_dir   <= DIR_STOP;
                r_speed <= '0;
                r_pwm_a <= '0;
                r_pwm_b <= '0;
            end else if (w_neg) begin
                r_dir   <= DIR_REVERSE;
                r_speed <= w_speed;
                r_pwm_a <= '0;
                r_pwm_b <= w_speed;
            end else begin
                r_dir   <= DIR_FORWARD;
                r_speed <= w_speed;
                r_pwm_a <= w_speed;
                r_pwm_b <= '0;
            end
        end
    end

    assign o_scaled_drive    = r_scaled_drive;
    assign o_motor_speed     = r_speed;
    assign o_motor_direction = r_dir;
    assign o_pwm_a_duty      = r_pwm_a;
    assign o_pwm_b_duty      = r_pwm_b;

endmodule

// File: sv/pid_motor_drive_core.sv
// ----------------------------------------------------------------------------
// pid_motor_drive_core - PID rate loop with H-bridge duty steering
// One PID tick per rate sample: error, saturating integral, gain sum,
// output scaling, then speed, direction and the two bridge duties.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  input     i_in_valid / o_in_ready     i_rate_sample
//  output    o_out_valid / i_out_ready   o_scaled_drive, o_motor_speed,
//                                        o_motor_direction, o_pwm_a_duty,
//                                        o_pwm_b_duty
//  config    i_cfg_wr_en                 i_cfg_idx, i_cfg_data
//
//  From acceptance to the output register, one shared 17 x ACC_WIDTH
//  multiplier runs five products in turn (three gains, two halves of the
//  output scale), each registered before it is summed. A new word is
//  taken only once the last has left the DONE state; the output register
//  lets the next word start while a result still waits.
//  Reset is synchronous and clears the integral, the last error, the
//  registers to their defaults and the sequencer; nothing else needs a pass.
// ----------------------------------------------------------------------------
module pid_motor_drive_core import pmd_pkg::*; #(
    parameter int ACC_WIDTH      = ACC_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [15:0]    i_rate_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_scaled_drive,
    output logic [7:0]            o_motor_speed,
    output logic signed [1:0]     o_motor_direction,
    output logic [7:0]            o_pwm_a_duty,
    output logic [7:0]            o_pwm_b_duty,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;

    pmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    pmd_datapath #(
        .ACC_WIDTH      (ACC_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_rate_sample     (i_rate_sample),
        .o_scaled_drive    (o_scaled_drive),
        .o_motor_speed     (o_motor_speed),
        .o_motor_direction (o_motor_direction),
        .o_pwm_a_duty      (o_pwm_a_duty),
        .o_pwm_b_duty      (o_pwm_b_duty)
    );

endmodule

// File: sim/pid_motor_drive_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_motor_drive_core_tb - self-checking bench for the PID motor drive core
// Rate samples are queued by a stimulus sequence and fed through a bursty
// valid/ready driver. Each accepted sample is run through a bit-exact PID
// predictor. The monitor drains results under a rotating stall pattern and
// compares every output word field by field. The gain settings change only
// while the core is idle. A final phase holds the error at both rails with
// every gain at full scale.
// ----------------------------------------------------------------------------
module pid_motor_drive_core_tb;
    import pmd_pkg::*;

    localparam int    HALF_PERIOD  = 5;
    localparam int    DRAIN_CYCLES = 12;
    localparam longint INTEG_MAX   = (64'sd1 <<< (ACC_WIDTH_DEF - 1)) - 1;
    localparam longint INTEG_MIN   = -INTEG_MAX - 1;
    localparam longint DRIVE_MAX   = 64'sd2147483647;
    localparam longint DRIVE_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] drive;
        logic [7:0]         speed;
        logic [1:0]         dir;
        logic [7:0]         duty_a;
        logic [7:0]         duty_b;
    } t_drive_word;

    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_ready;
    logic signed [15:0]    i_rate_sample     = '0;
    logic                  o_out_valid;
    logic                  i_out_ready       = 1'b0;
    logic signed [31:0]    o_scaled_drive;
    logic [7:0]            o_motor_speed;
    logic signed [1:0]     o_motor_direction;
    logic [7:0]            o_pwm_a_duty;
    logic [7:0]            o_pwm_b_duty;
    logic                  i_cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx         = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;

    // predictor copy of the registers and loop state
    logic signed [15:0] tgt_rate = TARGET_RATE_RST;
    longint             kp_g     = KP_GAIN_RST;
    longint             ki_g     = KI_GAIN_RST;
    longint             kd_g     = KD_GAIN_RST;
    longint             scale_g  = OUTPUT_SCALE_RST;
    longint             integ    = 0;
    longint             last_err = 0;

    logic signed [15:0] sample_q[$];
    t_drive_word        drive_q[$];

    logic        tx_gaps    = 1'b1;
    logic [15:0] rx_pattern = 16'hFFFF;
    int          burst_left = 0;
    int          gap_left   = 0;
    int          rx_pos     = 0;
    int          fault_cnt  = 0;
    t_drive_word want;
    t_drive_word got;
    bit          send;

    pid_motor_drive_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_rate_sample     (i_rate_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_scaled_drive    (o_scaled_drive),
        .o_motor_speed     (o_motor_speed),
        .o_motor_direction (o_motor_direction),
        .o_pwm_a_duty      (o_pwm_a_duty),
        .o_pwm_b_duty      (o_pwm_b_duty),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // One control tick: integral, gain sum, output scale, steering.
    function automatic t_drive_word pid_tick(input logic signed [15:0] sample);
        longint      err;
        longint      sum;
        longint      pid;
        longint      scaled;
        longint      mag;
        t_drive_word w;
        err   = tgt_rate - sample;
        integ = integ + err;
        if (integ > INTEG_MAX) begin
            integ = INTEG_MAX;
        end else if (integ < INTEG_MIN) begin
            integ = INTEG_MIN;
        end
        sum      = kp_g * err + ki_g * integ + kd_g * (err - last_err);
        last_err = err;
        pid      = sum >>> GAIN_FRAC_BITS_DEF;
        scaled   = (pid * scale_g) >>> 16;
        mag      = (scaled < 0) ? -scaled : scaled;
        w.speed  = (mag > 255) ? SPEED_MAX : mag[7:0];
        w.duty_a = '0;
        w.duty_b = '0;
        if (scaled > 0) begin
            w.dir    = DIR_FORWARD;
            w.duty_a = w.speed;
        end else if (scaled < 0) begin
            w.dir    = DIR_REVERSE;
            w.duty_b = w.speed;
        end else begin
            w.dir   = DIR_STOP;
            w.speed = '0;
        end
        if (scaled > DRIVE_MAX) begin
            scaled = DRIVE_MAX;
        end else if (scaled < DRIVE_MIN) begin
            scaled = DRIVE_MIN;
        end
        w.drive = scaled[31:0];
        return w;
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int near;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'($urandom);
            5, 6, 7: begin
                // track close to the set point so speed stays off the clamp
                near = int'(tgt_rate) + $urandom_range(0, 160) - 80;
                if (near > 32767) near = 32767;
                if (near < -32768) near = -32768;
                return 16'(near);
            end
            8: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            default: return tgt_rate;
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_TARGET_RATE:  tgt_rate = data;
            CFG_KP_GAIN:      kp_g     = data;
            CFG_KI_GAIN:      ki_g     = data;
            CFG_KD_GAIN:      kd_g     = data;
            CFG_OUTPUT_SCALE: scale_g  = data;
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [15:0] target, input logic [15:0] kp,
                                  input logic [15:0] ki, input logic [15:0] kd,
                                  input logic [15:0] scale);
        logic [CFG_IDX_W-1:0] junk_idx;
        junk_idx = CFG_IDX_W'($urandom_range(int'(CFG_OUTPUT_SCALE) + 1,
                                             (1 << CFG_IDX_W) - 1));
        cfg_write(CFG_TARGET_RATE, target);
        cfg_write(CFG_KP_GAIN, kp);
        cfg_write(junk_idx, 16'($urandom));
        cfg_write(CFG_KI_GAIN, ki);
        cfg_write(CFG_KD_GAIN, kd);
        cfg_write(CFG_OUTPUT_SCALE, scale);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // hold until every queued word is accepted and every result is back
    task automatic wait_idle();
        while (sample_q.size() != 0 || i_in_valid || drive_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pacing();
        tx_gaps <= ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
            0:       rx_pattern <= 16'hFFFF;
            1:       rx_pattern <= 16'($urandom) | 16'h0001;
            2:       rx_pattern <= 16'($urandom & $urandom) | 16'h0001;
            default: rx_pattern <= 16'($urandom | $urandom);
        endcase
    endtask

    task automatic queue_random(input int n);
        repeat (n) sample_q.push_back(pick_sample());
    endtask

    function automatic logic [15:0] pick_gain();
        return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 8191)) : 16'($urandom);
    endfunction

    // sender: bursts of words with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && o_in_ready)
                drive_q.push_back(pid_tick(i_rate_sample));
            if (!(i_in_valid && !o_in_ready)) begin
                send = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (sample_q.size() != 0)
                    send = 1'b1;
                if (send) begin
                    i_in_valid    <= 1'b1;
                    i_rate_sample <= sample_q.pop_front();
                    if (tx_gaps) begin
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 14);
                        end
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotate through the stall pattern and check each word taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_pos = 0;
        end else begin
            i_out_ready <= rx_pattern[rx_pos];
            rx_pos = (rx_pos + 1) % 16;
            if (o_out_valid && i_out_ready) begin
                got = '{o_scaled_drive, o_motor_speed, o_motor_direction,
                        o_pwm_a_duty, o_pwm_b_duty};
                if (drive_q.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("unexpected result word: drive %0d speed %0d dir %0d a %0d b %0d",
                                 got.drive, got.speed, $signed(got.dir), got.duty_a, got.duty_b);
                end else begin
                    want = drive_q.pop_front();
                    if (got !== want) begin
                        fault_cnt++;
                        if (fault_cnt <= 10)
                            $display({"result mismatch: expected drive %0d speed %0d dir %0d",
                                      " a %0d b %0d, got drive %0d speed %0d dir %0d a %0d b %0d"},
                                     want.drive, want.speed, $signed(want.dir), want.duty_a,
                                     want.duty_b, got.drive, got.speed, $signed(got.dir),
                                     got.duty_a, got.duty_b);
                    end
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains: error zero, both rails, single steps and step changes
        set_pacing();
        sample_q.push_back(16'sd300);
        sample_q.push_back(16'sd0);
        sample_q.push_back(16'sh8000);
        sample_q.push_back(16'sh7FFF);
        sample_q.push_back(16'sd301);
        sample_q.push_back(16'sd299);
        sample_q.push_back(-16'sd1);
        sample_q.push_back(16'sd1);
        sample_q.push_back(16'sh5555);
        sample_q.push_back(16'shAAAA);
        repeat (3) sample_q.push_back(16'sh7FFF);
        repeat (3) sample_q.push_back(16'sh8000);
        repeat (2) sample_q.push_back(16'sd300);
        wait_idle();

        // extreme gains and scale
        set_pacing();
        write_settings(16'h7FFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        sample_q.push_back(16'sh8000);
        sample_q.push_back(16'sh7FFF);
        sample_q.push_back(16'sh8000);
        sample_q.push_back(16'sh7FFE);
        queue_random(150);
        wait_idle();

        set_pacing();
        write_settings(16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001);
        queue_random(150);
        wait_idle();

        // zero scale forces a stop on every word
        set_pacing();
        write_settings(16'($urandom), pick_gain(), pick_gain(), pick_gain(), 16'h0000);
        queue_random(100);
        wait_idle();

        set_pacing();
        write_settings(16'($urandom_range(0, 2000)), KP_GAIN_RST, KI_GAIN_RST,
                       KD_GAIN_RST, OUTPUT_SCALE_RST);
        queue_random(130);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            set_pacing();
            write_settings(16'($urandom), pick_gain(), pick_gain(), pick_gain(),
                           ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 2047))
                                                       : 16'($urandom));
            queue_random(65);
            // let the pipeline run dry part way through
            if (p == 2)
                wait_idle();
            queue_random(65);
            wait_idle();
        end

        // hold the error at both rails with every gain at full scale
        tx_gaps    <= 1'b0;
        rx_pattern <= 16'hFFFF;
        write_settings(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (20) sample_q.push_back(16'sh7FFF);
        wait_idle();
        write_settings(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (20) sample_q.push_back(16'sh8000);
        queue_random(10);
        wait_idle();

        if (fault_cnt == 0 && drive_q.size() == 0) begin
            $display("pid_motor_drive_core test passed");
        end else begin
            $display("pid_motor_drive_core test failed");
        end
        $finish;
    end

    initial begin
        #(64'd40_000_000);
        $display("pid_motor_drive_core test failed");
        $finish;
    end

endmodule
